### rtl/pacs_pkg.sv
// ---------------------------------------------------------------------------
// pacs_pkg: shared definitions for the priority alarm change scanner
// Field widths, register reset value, action codes and result word layout.
// ---------------------------------------------------------------------------
`default_nettype none

package pacs_pkg;

   localparam int NUM_INPUTS_DEF = 11;
   localparam int LEVEL_W        = 11;
   localparam int TIME_W         = 32;
   localparam int DEBOUNCE_W     = 16;
   localparam int INDEX_W        = 4;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   // request word: now_ms, levels; padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int REQ_NOW_LO = 0;
   localparam int REQ_LVL_LO = TIME_W;

   // result word: event_valid, input_index, new_level, severity
   localparam int RSP_DATA_W = 8;
   localparam int RSP_EV_BIT  = 0;
   localparam int RSP_IDX_LO  = 1;
   localparam int RSP_LVL_BIT = RSP_IDX_LO + INDEX_W;
   localparam int RSP_SEV_BIT = RSP_LVL_BIT + 1;

   typedef enum logic {
      ACT_INIT = 1'b0,
      ACT_SCAN = 1'b1
   } action_type;

endpackage

`default_nettype wire

### rtl/priority_alarm_change_scanner.sv
// ---------------------------------------------------------------------------
// priority_alarm_change_scanner: debounced priority change scan of alarm inputs
//
// Usage:
//   req_* carries one word per init or scan: tuser is the action
//   (init or scan), tdata holds now_ms and the current input levels.
//   rsp_* returns exactly one word per request: event flag, index of the
//   changed input, its new level and severity.
//   csr_* writes the 16-bit debounce time; it is always ready and should
//   only be written while no request is in flight.
// Path: a request passes the input register, then the result register,
//   before its result shows on rsp_*.
// Throughput: one request per cycle while rsp_tready is high; the
//   elapsed-time compares of all inputs and the priority pick sit in the
//   combinational logic between the input register and the result register.
// Reset: clears all stored levels and check times to zero, debounce to
//   20 ms, and empties both registers.
// Stall: while rsp_tready is low the result holds; one more request is
//   taken into the input register, then req_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_alarm_change_scanner
   import pacs_pkg::*;
#(
   parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // now_ms[31:0], levels[42:32], zero pad
   input  wire logic [0:0]            req_tuser,  // action[0]
   // result
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // event_valid[0], input_index[4:1],
                                                  // new_level[5], severity[6], zero pad
   // debounce register
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [DEBOUNCE_W-1:0] csr_data
);

   // input register
   logic              in_valid_ff, in_valid_in;
   action_type        in_action_ff;
   logic [TIME_W-1:0] in_now_ff;
   logic [LEVEL_W-1:0] in_levels_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_event_ff, rsp_event_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_level_ff, rsp_level_in;

   // alarm state
   logic [NUM_INPUTS-1:0] stored_level_ff, stored_level_in;
   logic [TIME_W-1:0]     last_check_ff [NUM_INPUTS];
   logic [TIME_W-1:0]     last_check_in [NUM_INPUTS];
   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;

   logic                  advance;
   logic [NUM_INPUTS-1:0] cur_level;
   logic [NUM_INPUTS-1:0] qualified;
   logic [NUM_INPUTS-1:0] changed;
   logic [NUM_INPUTS-1:0] visited;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      debounce_in = debounce_ff;
      if (csr_valid && csr_ready) begin
         debounce_in = csr_data;
      end
   end

   // per-input level and elapsed-time check; inputs past the levels field read 0
   for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_input
      logic [TIME_W-1:0] elapsed;
      if (g < LEVEL_W) begin : g_lvl
         assign cur_level[g] = in_levels_ff[g];
      end else begin : g_zero
         assign cur_level[g] = 1'b0;
      end
      assign elapsed      = in_now_ff - last_check_ff[g];
      assign qualified[g] = elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff};
      assign changed[g]   = qualified[g] && (cur_level[g] != stored_level_ff[g]);
   end

   // priority pick: the scan stops at the first qualified change
   always_comb begin
      logic blocked;
      blocked      = 1'b0;
      rsp_event_in = 1'b0;
      rsp_index_in = '0;
      rsp_level_in = 1'b0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         visited[i] = !blocked;
         if (!blocked && changed[i]) begin
            blocked      = 1'b1;
            rsp_event_in = 1'b1;
            rsp_index_in = INDEX_W'(i);
            rsp_level_in = cur_level[i];
         end
      end
   end

   always_comb begin
      stored_level_in = stored_level_ff;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         last_check_in[i] = last_check_ff[i];
         if (advance) begin
            if (in_action_ff == ACT_INIT) begin
               stored_level_in[i] = cur_level[i];
               last_check_in[i]   = in_now_ff;
            end else if (visited[i] && qualified[i]) begin
               stored_level_in[i] = cur_level[i];
               last_check_in[i]   = in_now_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stored_level_ff <= '0;
         debounce_ff     <= DEBOUNCE_RESET;
         for (int i = 0; i < NUM_INPUTS; i++) begin
            last_check_ff[i] <= '0;
         end
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         stored_level_ff <= stored_level_in;
         debounce_ff     <= debounce_in;
         for (int i = 0; i < NUM_INPUTS; i++) begin
            last_check_ff[i] <= last_check_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= action_type'(req_tuser[0]);
         in_now_ff    <= req_tdata[REQ_NOW_LO +: TIME_W];
         in_levels_ff <= req_tdata[REQ_LVL_LO +: LEVEL_W];
      end
      if (advance) begin
         // init words report nothing
         rsp_event_ff <= (in_action_ff == ACT_SCAN) && rsp_event_in;
         rsp_index_ff <= (in_action_ff == ACT_SCAN) ? rsp_index_in : '0;
         rsp_level_ff <= (in_action_ff == ACT_SCAN) && rsp_level_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                          = '0;
      rsp_tdata[RSP_EV_BIT]              = rsp_event_ff;
      rsp_tdata[RSP_IDX_LO +: INDEX_W]   = rsp_index_ff;
      rsp_tdata[RSP_LVL_BIT]             = rsp_level_ff;
      rsp_tdata[RSP_SEV_BIT]             = rsp_level_ff;
   end

endmodule

`default_nettype wire

### rtl/pacs_checker.sv
// ---------------------------------------------------------------------------
// pacs_checker: port-level checks for the priority alarm change scanner
// Watches the result channel for holding, reset, field consistency and arrival.
// ---------------------------------------------------------------------------
`default_nettype none

module pacs_checker
   import pacs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // nothing comes out in the cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // without an event the other fields are zero
   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_EV_BIT] |-> rsp_tdata[RSP_SEV_BIT:RSP_IDX_LO] == '0)
      else $error("fields set without event");

   // severity follows the new level
   a_sev_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_SEV_BIT] == rsp_tdata[RSP_LVL_BIT])
      else $error("severity does not match new level");

   // a word accepted into an empty block shows up once it has passed both registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing after request");

endmodule

bind priority_alarm_change_scanner pacs_checker u_pacs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/sv/tb_priority_alarm_change_scanner.sv
// ---------------------------------------------------------------------------
// tb_priority_alarm_change_scanner: self-checking bench for the alarm scanner
// Init and scan words go in with random gaps and response back-pressure.
// Every returned word is checked against an in-bench model of the debounced
// priority scan. The debounce register is swept over its range between
// phases while the block is drained.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_priority_alarm_change_scanner;
   import pacs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AT_RESULT = 300;
   localparam int PAD_W          = REQ_DATA_W - TIME_W - LEVEL_W;

   typedef struct packed {
      action_type          action;
      logic [TIME_W-1:0]   now;
      logic [LEVEL_W-1:0]  levels;
   } scan_req_type;

   typedef struct packed {
      logic                ev;
      logic [INDEX_W-1:0]  idx;
      logic                lvl;
      logic                sev;
   } scan_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [DEBOUNCE_W-1:0] csr_data = '0;

   // model state
   logic [NUM_INPUTS_DEF-1:0] held_level;
   logic [TIME_W-1:0]         check_stamp [NUM_INPUTS_DEF];
   logic [DEBOUNCE_W-1:0]     debounce_q;

   scan_req_type scan_req_q[$];
   scan_rsp_type scan_result_q[$];
   scan_req_type req_word;
   int        req_gap = 0;
   int        stall_left = 0;
   int        hold_left = 0;
   bit        hold_done = 0;
   int        rsp_count = 0;
   int        mismatch_cnt = 0;
   int        quiet_cycles = 0;

   // random stimulus context
   logic [TIME_W-1:0]  gen_now;
   logic [LEVEL_W-1:0] gen_levels;

   priority_alarm_change_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // now_ms[31:0], levels[42:32], zero pad
      .req_tuser  (req_tuser),   // action[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // event_valid[0], input_index[4:1], new_level[5],
                                 // severity[6], zero pad
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Debounced priority scan: first qualifying changed input wins.
   function automatic scan_rsp_type predict_scan(scan_req_type r);
      scan_rsp_type      res;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      if (r.action == ACT_INIT) begin
         for (int i = 0; i < NUM_INPUTS_DEF; i++) begin
            held_level[i]  = r.levels[i];
            check_stamp[i] = r.now;
         end
         return res;
      end
      for (int i = 0; i < NUM_INPUTS_DEF; i++) begin
         elapsed = r.now - check_stamp[i];
         if (elapsed >= debounce_q) begin
            check_stamp[i] = r.now;
            if (r.levels[i] != held_level[i]) begin
               held_level[i] = r.levels[i];
               res.ev  = 1'b1;
               res.idx = INDEX_W'(i);
               res.lvl = r.levels[i];
               res.sev = r.levels[i];
               return res;
            end
         end
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_result_q.push_back(predict_scan(req_word));
            req_gap = pick_gap();
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (scan_req_q.size() > 0) begin
               req_word = scan_req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{PAD_W{1'b0}}, req_word.levels, req_word.now};
               req_tuser  <= req_word.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin : rsp_monitor
      scan_rsp_type got;
      scan_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ev  = rsp_tdata[RSP_EV_BIT];
            got.idx = rsp_tdata[RSP_IDX_LO +: INDEX_W];
            got.lvl = rsp_tdata[RSP_LVL_BIT];
            got.sev = rsp_tdata[RSP_SEV_BIT];
            rsp_count++;
            if (scan_result_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected result word: ev=%0b idx=%0d lvl=%0b sev=%0b",
                           got.ev, got.idx, got.lvl, got.sev);
            end else begin
               want = scan_result_q.pop_front();
               if (got.ev !== want.ev || got.idx !== want.idx ||
                   got.lvl !== want.lvl || got.sev !== want.sev) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("result %0d: expected ev=%0b idx=%0d lvl=%0b sev=%0b, %s",
                              rsp_count, want.ev, want.idx, want.lvl, want.sev,
                              $sformatf("got ev=%0b idx=%0d lvl=%0b sev=%0b",
                                        got.ev, got.idx, got.lvl, got.sev));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT_RESULT) begin
            // long hold-off so the block backs up and stalls its input
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_word(action_type act, logic [TIME_W-1:0] now,
                            logic [LEVEL_W-1:0] lv);
      scan_req_type w;
      w.action = act;
      w.now    = now;
      w.levels = lv;
      scan_req_q.push_back(w);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (scan_req_q.size() != 0 || req_tvalid || scan_result_q.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_debounce(logic [DEBOUNCE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      debounce_q = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly plausible time-ordered scans with a few toggled inputs; some
   // re-inits and some fully random words as noise.
   task automatic gen_random(int count);
      int          r;
      int unsigned span;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            if ($urandom_range(0, 1)) gen_now = $urandom;
            if ($urandom_range(0, 1)) gen_levels = LEVEL_W'($urandom);
            push_word(ACT_INIT, gen_now, gen_levels);
         end else if (r < 12) begin
            gen_now    = $urandom;
            gen_levels = LEVEL_W'($urandom);
            push_word(ACT_SCAN, gen_now, gen_levels);
         end else begin
            if ($urandom_range(0, 9) < 7)
               span = debounce_q + debounce_q / 2 + 2;
            else
               span = 4 * debounce_q + 8;
            gen_now = gen_now + TIME_W'($urandom_range(0, span));
            r = $urandom_range(0, 99);
            if (r < 45)
               gen_levels[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
            else if (r < 55)
               gen_levels ^= LEVEL_W'($urandom);
            push_word(ACT_SCAN, gen_now, gen_levels);
         end
      end
   endtask

   initial begin
      held_level = '0;
      for (int i = 0; i < NUM_INPUTS_DEF; i++) check_stamp[i] = '0;
      debounce_q = DEBOUNCE_RESET;
      gen_now    = $urandom;
      gen_levels = LEVEL_W'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: scan before init, debounce edge, wrap, every index, extremes
      push_word(ACT_SCAN, 32'd0, 11'h000);
      push_word(ACT_SCAN, 32'd19, 11'h7FF);
      push_word(ACT_SCAN, 32'd20, 11'h7FF);
      push_word(ACT_SCAN, 32'd20, 11'h7FF);
      push_word(ACT_INIT, 32'hFFFF_FFFF, 11'h7FF);
      push_word(ACT_SCAN, 32'h0000_0013, 11'h3FF);
      push_word(ACT_SCAN, 32'h0000_0014, 11'h000);
      push_word(ACT_INIT, 32'd0, 11'h000);
      push_word(ACT_SCAN, 32'hFFFF_FFFF, 11'h7FF);
      for (int i = 1; i < NUM_INPUTS_DEF; i++)
         push_word(ACT_SCAN, 32'hFFFF_FFFF + 32'(20 * i), 11'h7FF);
      push_word(ACT_SCAN, 32'hFFFF_FFFF + 32'd400, 11'h555);
      push_word(ACT_SCAN, 32'hFFFF_FFFF + 32'd420, 11'h2AA);
      push_word(ACT_INIT, 32'hFFFF_FFFF, 11'h000);
      push_word(ACT_SCAN, 32'hFFFF_FFFF, 11'h7FF);
      gen_random(170);
      wait_drained();

      write_debounce(16'd0);
      gen_random(190);
      wait_drained();
      write_debounce(16'hFFFF);
      gen_random(190);
      wait_drained();
      write_debounce(16'd1);
      gen_random(190);
      wait_drained();
      write_debounce(DEBOUNCE_W'($urandom_range(2, 65534)));
      gen_random(190);
      wait_drained();
      write_debounce(DEBOUNCE_W'($urandom_range(3, 60)));
      gen_random(190);
      wait_drained();

      repeat (10) @(posedge clock);
      mismatch_cnt += scan_result_q.size();
      if (mismatch_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
